// ===== hw/rtl/u8sd_pkg.sv =====
// u8sd_pkg: shared constants and types for the UTF-8 stream decoder.
// No dependencies; used by the front, queue, back and top files and the bench.
package u8sd_pkg;

  localparam int unsigned CpW = 21;

  localparam logic [CpW-1:0] Replacement = 21'h00FFFD;
  localparam logic [CpW-1:0] MaxScalar   = 21'h10FFFF;
  localparam logic [CpW-1:0] SurrLo      = 21'h00D800;
  localparam logic [CpW-1:0] SurrHi      = 21'h00DFFF;

  // Continuation bytes needed in all by an open sequence.
  localparam logic [1:0] NeedNone  = 2'd0;
  localparam logic [1:0] NeedOne   = 2'd1;
  localparam logic [1:0] NeedTwo   = 2'd2;
  localparam logic [1:0] NeedThree = 2'd3;

  // One classified byte: rep_cnt replacement words, then an optional scalar.
  typedef struct packed {
    logic [2:0]     rep_cnt;
    logic           has_cp;
    logic [CpW-1:0] cp;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== hw/rtl/u8sd_if.sv =====
// u8sd_if: valid/ready channel interfaces of the UTF-8 stream decoder.
// Depends on nothing; byte channel in, code point channel out.
interface u8sd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_stream;

  modport source (output valid, output data_byte, output end_of_stream, input ready);
  modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface u8sd_out_if;
  logic        valid;
  logic        ready;
  logic [20:0] code_point;
  logic        replaced;
  logic        last_of_run;

  modport source (output valid, output code_point, output replaced, output last_of_run,
                  input ready);
  modport sink   (input valid, input code_point, input replaced, input last_of_run,
                  output ready);
endinterface

// ===== hw/rtl/u8sd_front.sv =====
// u8sd_front: accepts bytes, tracks the open sequence, classifies each byte
// into a queue entry. Depends on u8sd_pkg and u8sd_in_if.
module u8sd_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  u8sd_in_if.sink            in_i,
  input  u8sd_pkg::q_stat_t  stat_i,
  output logic               push_o,
  output u8sd_pkg::entry_t   entry_o
);

  logic [1:0]  need_q, need_d;
  logic [1:0]  held_q, held_d;
  logic [20:0] part_q, part_d;
  logic        accept;

  assign in_i.ready = !stat_i.full;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    logic [7:0]  b;
    logic        fresh;
    logic [20:0] acc;
    logic [1:0]  held_inc;
    logic [2:0]  rep;
    logic        has_cp;
    logic [20:0] cp;
    b        = in_i.data_byte;
    fresh    = 1'b0;
    acc      = {part_q[14:0], b[5:0]};
    held_inc = held_q + 2'd1;
    rep      = 3'd0;
    has_cp   = 1'b0;
    cp       = {13'd0, b};
    need_d   = need_q;
    held_d   = held_q;
    part_d   = part_q;

    if (need_q == u8sd_pkg::NeedNone) begin
      fresh = 1'b1;
    end else if (b[7:6] != 2'b10) begin
      // broken sequence: lead and held bytes each become U+FFFD
      rep    = 3'd1 + {1'b0, held_q};
      fresh  = 1'b1;
      need_d = u8sd_pkg::NeedNone;
      held_d = 2'd0;
      part_d = '0;
    end else if (held_inc == need_q) begin
      if (acc > u8sd_pkg::MaxScalar ||
          (acc >= u8sd_pkg::SurrLo && acc <= u8sd_pkg::SurrHi)) begin
        rep = 3'd1 + {1'b0, need_q};
      end else begin
        has_cp = 1'b1;
        cp     = acc;
      end
      need_d = u8sd_pkg::NeedNone;
      held_d = 2'd0;
      part_d = '0;
    end else begin
      held_d = held_inc;
      part_d = acc;
    end

    if (fresh) begin
      if (!b[7]) begin
        has_cp = 1'b1;
        cp     = {13'd0, b};
      end else if (b[7:5] == 3'b110) begin
        need_d = u8sd_pkg::NeedOne;
        held_d = 2'd0;
        part_d = {16'd0, b[4:0]};
      end else if (b[7:4] == 4'b1110) begin
        need_d = u8sd_pkg::NeedTwo;
        held_d = 2'd0;
        part_d = {17'd0, b[3:0]};
      end else if (b[7:3] == 5'b11110) begin
        need_d = u8sd_pkg::NeedThree;
        held_d = 2'd0;
        part_d = {18'd0, b[2:0]};
      end else begin
        rep = rep + 3'd1;
      end
    end

    // truncation flush
    if (in_i.end_of_stream && need_d != u8sd_pkg::NeedNone) begin
      rep    = rep + 3'd1 + {1'b0, held_d};
      need_d = u8sd_pkg::NeedNone;
      held_d = 2'd0;
      part_d = '0;
    end

    entry_o.rep_cnt = rep;
    entry_o.has_cp  = has_cp;
    entry_o.cp      = cp;
  end

  assign push_o = accept && (entry_o.rep_cnt != 3'd0 || entry_o.has_cp);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      need_q <= u8sd_pkg::NeedNone;
      held_q <= 2'd0;
      part_q <= '0;
    end else if (accept) begin
      need_q <= need_d;
      held_q <= held_d;
      part_q <= part_d;
    end
  end

endmodule

// ===== hw/rtl/u8sd_queue.sv =====
// u8sd_queue: two-entry queue of classified bytes between front and back.
// Depends on u8sd_pkg.
module u8sd_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  u8sd_pkg::entry_t   entry_i,
  input  logic               pop_i,
  output u8sd_pkg::entry_t   head_o,
  output u8sd_pkg::q_stat_t  stat_o
);

  u8sd_pkg::entry_t mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;

  assign head_o       = mem_q[rd_ptr_q];
  assign stat_o.full  = (cnt_q == 2'd2);
  assign stat_o.empty = (cnt_q == 2'd0);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= !wr_ptr_q;
      if (pop_i)  rd_ptr_q <= !rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

// ===== hw/rtl/u8sd_back.sv =====
// u8sd_back: expands queue entries into output words, one per cycle while out_o
// is ready, through an output register. Depends on u8sd_pkg and u8sd_out_if.
module u8sd_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  u8sd_pkg::entry_t   head_i,
  input  u8sd_pkg::q_stat_t  stat_i,
  output logic               pop_o,
  u8sd_out_if.source         out_o
);

  logic        out_valid_q;
  logic [20:0] cp_q;
  logic        repl_q, last_q;
  logic [1:0]  sent_q;

  logic        load, take;
  logic [2:0]  total;
  logic        is_rep, is_last;

  assign load    = !out_valid_q || out_o.ready;
  assign take    = load && !stat_i.empty;
  assign total   = head_i.rep_cnt + {2'd0, head_i.has_cp};
  assign is_rep  = ({1'b0, sent_q} < head_i.rep_cnt);
  assign is_last = ({1'b0, sent_q} + 3'd1 == total);
  assign pop_o   = take && is_last;

  always_ff @(posedge clk_i) begin
    if (take) begin
      cp_q   <= is_rep ? u8sd_pkg::Replacement : head_i.cp;
      repl_q <= is_rep;
      last_q <= is_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sent_q      <= 2'd0;
    end else begin
      if (load) out_valid_q <= !stat_i.empty;
      if (take) sent_q <= is_last ? 2'd0 : sent_q + 2'd1;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.code_point  = cp_q;
  assign out_o.replaced    = repl_q;
  assign out_o.last_of_run = last_q;

endmodule

// ===== hw/rtl/utf8_stream_decoder.sv =====
// utf8_stream_decoder: top level, byte-in / code-point-out UTF-8 decoder.
// Depends on u8sd_pkg, u8sd_if, u8sd_front, u8sd_queue and u8sd_back.
//
// Takes one byte per word on in_i and emits Unicode scalar values on out_o.
// Bytes below 0x80 pass straight through; C0..DF, E0..EF and F0..F7 open
// 2-, 3- and 4-byte sequences, and a completed sequence yields one word.
// Overlong forms are accepted. Any rejected sequence (bad lead, broken
// sequence, surrogate or above 0x10FFFF, or truncation by end_of_stream)
// produces one U+FFFD with replaced=1 per byte it consumed, then decoding
// resumes on the next byte. A byte that only opens or extends a sequence
// produces no word; otherwise last_of_run marks the final word caused by it.
// Rate: one byte per cycle as long as each byte yields at most one word and
// out_o does not stall. A byte that yields k words (k up to 4) keeps the
// output busy for k words, since the back end drives one word per cycle,
// stalls apart, from its output register; the two-entry queue lets the front
// keep taking bytes that produce no word meanwhile. An accepted byte's words
// pass through a queue entry, then the output register. No clearing pass after reset.
module utf8_stream_decoder (
  input  logic         clk_i,
  input  logic         rst_ni,
  u8sd_in_if.sink      in_i,
  u8sd_out_if.source   out_o
);

  u8sd_pkg::entry_t  push_entry;
  u8sd_pkg::entry_t  head;
  u8sd_pkg::q_stat_t stat;
  logic              push, pop;

  // front: sequence state and per-byte classification
  u8sd_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .stat_i  (stat),
    .push_o  (push),
    .entry_o (push_entry)
  );

  // queue decouples byte intake from word delivery
  u8sd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .head_o  (head),
    .stat_o  (stat)
  );

  // back: burst expansion and output register
  u8sd_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head),
    .stat_i  (stat),
    .pop_o   (pop),
    .out_o   (out_o)
  );

  // a decoded scalar always closes its byte's run
  a_cp_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.replaced |-> out_o.last_of_run)
    else $error("scalar word not marked last_of_run");

  // replacement words carry U+FFFD
  a_repl_val: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.replaced |-> out_o.code_point == u8sd_pkg::Replacement)
    else $error("replacement word with wrong code point");

  // the front never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !stat.full)
    else $error("queue overflow");

  // the back never pops an empty queue
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !stat.empty)
    else $error("queue underflow");

endmodule

// ===== test/utf8_stream_decoder_tb.sv =====
// utf8_stream_decoder_tb: self-checking bench for the byte-serial UTF-8 decoder.
// Needs u8sd_pkg, u8sd_if and the utf8_stream_decoder RTL; nothing else.
// A byte driver and a code point monitor run against a behavioral decoder model.
module utf8_stream_decoder_tb;

  typedef logic [u8sd_pkg::CpW-1:0] cp_t;

  typedef struct packed {
    logic [7:0] data;
    logic       eos;
    logic       drain;   // hold this byte back until all words are in
  } byte_item_t;

  typedef struct packed {
    cp_t  cp;
    logic repl;
    logic last;
  } cp_word_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b1;

  always #5 clk_i = ~clk_i;

  u8sd_in_if  in_ch ();
  u8sd_out_if out_ch ();

  utf8_stream_decoder dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source)
  );

  // Byte stream waiting to be sent, and the words the decoder owes us.
  byte_item_t pending_bytes[$];
  cp_word_t   expected_words[$];
  cp_word_t   run_words[$];      // words caused by the byte being decoded
  int         n_items    = 0;
  logic       drain_next = 1'b0;

  int bytes_in;     // bytes taken by the block (nonblocking, driver owned)
  int words_due;    // words predicted so far (driver owned)
  int words_got;    // words taken from the block (nonblocking, monitor owned)
  int errors = 0;

  // Decoder state of the model.
  logic [1:0] need_q;
  logic [1:0] held_q;
  cp_t        part_q;

  // ---------------------------------------------------------------------------
  // Decoder model
  // ---------------------------------------------------------------------------
  function automatic void emit_word(cp_t cp, logic repl);
    cp_word_t w;
    if (run_words.size() < 4) begin
      w.cp   = cp;
      w.repl = repl;
      w.last = 1'b0;
      run_words = {run_words, w};
    end
  endfunction

  function automatic void close_seq();
    need_q = u8sd_pkg::NeedNone;
    held_q = 2'd0;
    part_q = '0;
  endfunction

  // One U+FFFD for the lead and one per continuation byte held so far.
  function automatic void flush_open();
    emit_word(u8sd_pkg::Replacement, 1'b1);
    for (int k = 0; k < held_q; k++) emit_word(u8sd_pkg::Replacement, 1'b1);
    close_seq();
  endfunction

  function automatic void start_fresh(logic [7:0] b);
    if (b < 8'h80) begin
      emit_word(cp_t'(b), 1'b0);
    end else if ((b & 8'hE0) == 8'hC0) begin
      need_q = u8sd_pkg::NeedOne;
      held_q = 2'd0;
      part_q = cp_t'(b[4:0]);
    end else if ((b & 8'hF0) == 8'hE0) begin
      need_q = u8sd_pkg::NeedTwo;
      held_q = 2'd0;
      part_q = cp_t'(b[3:0]);
    end else if ((b & 8'hF8) == 8'hF0) begin
      need_q = u8sd_pkg::NeedThree;
      held_q = 2'd0;
      part_q = cp_t'(b[2:0]);
    end else begin
      emit_word(u8sd_pkg::Replacement, 1'b1);   // stray continuation or F8..FF
    end
  endfunction

  task automatic predict_byte(input logic [7:0] b, input logic eos);
    run_words.delete();
    if (need_q == u8sd_pkg::NeedNone) begin
      start_fresh(b);
    end else if (b[7:6] != 2'b10) begin
      // sequence broken: reject what is held, then decode this byte afresh
      flush_open();
      start_fresh(b);
    end else begin
      part_q = {part_q[u8sd_pkg::CpW-7:0], b[5:0]};
      held_q = held_q + 2'd1;
      if (held_q >= need_q) begin
        if (part_q > u8sd_pkg::MaxScalar ||
            (part_q >= u8sd_pkg::SurrLo && part_q <= u8sd_pkg::SurrHi)) begin
          for (int k = 0; k <= need_q; k++) emit_word(u8sd_pkg::Replacement, 1'b1);
        end else begin
          emit_word(part_q, 1'b0);
        end
        close_seq();
      end
    end
    if (eos && need_q != u8sd_pkg::NeedNone) flush_open();   // truncated at end of stream
    if (run_words.size() > 0) run_words[run_words.size() - 1].last = 1'b1;
    expected_words = {expected_words, run_words};
    words_due += run_words.size();
  endtask

  // ---------------------------------------------------------------------------
  // Idle gaps: mostly none or short, a few long, now and then a calm stretch.
  // ---------------------------------------------------------------------------
  function automatic int next_gap(ref int calm_left);
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) calm_left = $urandom_range(10, 30);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 9);
    return $urandom_range(15, 40);
  endfunction

  task automatic report_mismatch(input string what, input cp_t got, input cp_t want);
    errors++;
    $display("%0t mismatch on %s: got %h, want %h", $time, what, got, want);
  endtask

  function automatic void queue_byte(logic [7:0] b, logic eos = 1'b0);
    byte_item_t it;
    it.data    = b;
    it.eos     = eos;
    it.drain   = drain_next;
    drain_next = 1'b0;
    pending_bytes = {pending_bytes, it};
    n_items++;
  endfunction

  // ---------------------------------------------------------------------------
  // Byte driver
  // ---------------------------------------------------------------------------
  int         tx_gap;
  int         tx_calm = 0;
  logic       tx_fire;
  byte_item_t tx_item;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid         <= 1'b0;
      in_ch.data_byte     <= '0;
      in_ch.end_of_stream <= 1'b0;
      bytes_in            <= 0;
      words_due           = 0;
      tx_gap              = 0;
      close_seq();
    end else begin
      tx_fire = in_ch.valid && in_ch.ready;
      if (tx_fire) begin
        predict_byte(in_ch.data_byte, in_ch.end_of_stream);
        bytes_in <= bytes_in + 1;
        tx_gap = next_gap(tx_calm);
      end
      // an offered byte stays up until taken
      if (!in_ch.valid || tx_fire) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_ch.valid <= 1'b0;
        end else if (pending_bytes.size() != 0 &&
                     !(pending_bytes[0].drain && words_got != words_due)) begin
          tx_item = pending_bytes.pop_front();
          in_ch.valid         <= 1'b1;
          in_ch.data_byte     <= tx_item.data;
          in_ch.end_of_stream <= tx_item.eos;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Code point monitor and back-pressure
  // ---------------------------------------------------------------------------
  int       rx_stall;
  int       rx_calm = 0;
  logic     long_hold_done;
  cp_word_t rx_want;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready   <= 1'b0;
      words_got      <= 0;
      rx_stall       = 0;
      long_hold_done = 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        words_got <= words_got + 1;
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected word", out_ch.code_point, '0);
        end else begin
          rx_want = expected_words.pop_front();
          if (out_ch.code_point !== rx_want.cp)
            report_mismatch("code_point", out_ch.code_point, rx_want.cp);
          if (out_ch.replaced !== rx_want.repl)
            report_mismatch("replaced", cp_t'(out_ch.replaced), cp_t'(rx_want.repl));
          if (out_ch.last_of_run !== rx_want.last)
            report_mismatch("last_of_run", cp_t'(out_ch.last_of_run), cp_t'(rx_want.last));
        end
        rx_stall = next_gap(rx_calm);
      end
      // one long hold-off mid-run so the block backs up into its input
      if (!long_hold_done && bytes_in >= 40) begin
        long_hold_done = 1'b1;
        rx_stall       = 150;
      end
      if (rx_stall > 0) begin
        rx_stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int n_rand;
    int kind;
    int len;
    int cut;
    logic eos_end;
    logic [7:0] lead;

    rst_ni <= 1'b0;

    // ASCII extremes, end of stream on a plain byte
    queue_byte(8'h00);
    queue_byte(8'h7F, 1'b1);
    // overlong two-byte NUL is accepted
    queue_byte(8'hC0); queue_byte(8'h80);
    // four-byte scalar U+1F600
    queue_byte(8'hF0); queue_byte(8'h9F); queue_byte(8'h98); queue_byte(8'h80);
    // a real U+FFFD, not flagged as replaced
    queue_byte(8'hEF); queue_byte(8'hBF); queue_byte(8'hBD);
    // bad leads: stray continuation and F8..FF
    queue_byte(8'h80); queue_byte(8'hFF);
    // broken three-byte sequence followed by 'A'
    queue_byte(8'hE2); queue_byte(8'h82); queue_byte(8'h41);
    // surrogate U+D800
    queue_byte(8'hED); queue_byte(8'hA0); queue_byte(8'h80);
    // above U+10FFFF
    queue_byte(8'hF4); queue_byte(8'h90); queue_byte(8'h80); queue_byte(8'h80);
    // truncated by end of stream
    queue_byte(8'hF0); queue_byte(8'h9F); queue_byte(8'h98, 1'b1);

    // Random part: mostly well-formed sequences, some truncated, some noise.
    drain_next = 1'b1;
    n_rand = 0;
    while (n_rand < 75) begin
      kind    = $urandom_range(0, 9);
      eos_end = ($urandom_range(0, 7) == 0);
      if (kind <= 7) begin
        len = $urandom_range(2, 4);
        case (len)
          2:       lead = 8'hC0 | 8'($urandom_range(0, 31));
          3:       lead = 8'hE0 | 8'($urandom_range(0, 15));
          default: lead = 8'hF0 | 8'($urandom_range(0, 7));
        endcase
      end
      case (kind)
        0, 1, 2: begin
          queue_byte(8'($urandom_range(0, 127)), eos_end);
          n_rand++;
        end
        3, 4, 5, 6: begin
          queue_byte(lead);
          for (int k = 1; k < len; k++)
            queue_byte(8'h80 | 8'($urandom_range(0, 63)), eos_end && k == len - 1);
          n_rand += len;
        end
        7: begin
          // cut short: a following byte that is not a continuation breaks it, or end of stream flushes it
          cut = $urandom_range(1, len - 1);
          queue_byte(lead, eos_end && cut == 1);
          for (int k = 1; k < cut; k++)
            queue_byte(8'h80 | 8'($urandom_range(0, 63)), eos_end && k == cut - 1);
          n_rand += cut;
        end
        default: begin
          queue_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
          n_rand++;
        end
      endcase
      if (n_rand >= 40 && n_rand < 45) drain_next = 1'b1;
    end

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (bytes_in != n_items) @(posedge clk_i);
    while (words_got != words_due) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (expected_words.size() != 0)
      report_mismatch("words never delivered", '0, cp_t'(expected_words.size()));

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule
